[design/chd_pkg.sv]
package chd_pkg;

   // Width of the chunk length counter
   localparam int unsigned LenWidth = 32;

   localparam logic [7:0] CharLf = 8'h0a;
   localparam logic [7:0] CharCr = 8'h0d;

   typedef enum logic [3:0] {
      PH_LEN      = 4'd0,
      PH_EXT      = 4'd1,
      PH_DATA     = 4'd2,
      PH_TERM     = 4'd3,
      PH_TERM_CR  = 4'd4,
      PH_TRL      = 4'd5,
      PH_TRL_SKIP = 4'd6,
      PH_TRL_CR   = 4'd7,
      PH_WAIT_EOF = 4'd8,
      PH_DONE     = 4'd9,
      PH_ERR      = 4'd10
   } phase_type;

   typedef enum logic [1:0] {
      MODE_AT_TRAILER    = 2'd0,
      MODE_AFTER_TRAILER = 2'd1,
      MODE_ADOPT         = 2'd2,
      MODE_AT_FINAL_EXT  = 2'd3
   } stop_mode_type;

   typedef enum logic [1:0] {
      KIND_NONE     = 2'd0,
      KIND_PAYLOAD  = 2'd1,
      KIND_LEFTOVER = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DECODING = 2'd0,
      STATUS_FINISHED = 2'd1,
      STATUS_ERROR    = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   out_kind;
      status_type status;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] b);
      hex_type h;
      h.ok  = 1'b1;
      h.val = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.val = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.val = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.val = 4'(b - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

[design/chd_in_stage.sv]
module chd_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] in_byte
   input  logic                 req_tlast,   // end_of_input
   input  logic                 out_ready,
   output logic                 item_valid,
   output chd_pkg::item_type    item
);
   import chd_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign req_tready = !valid_ff || out_ready;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.in_byte      <= req_tdata;
         item_ff.end_of_input <= req_tlast;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[design/chd_core.sv]
module chd_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [1:0]           csr_wr_data,
   input  logic                 fire,
   input  chd_pkg::item_type    item,
   output chd_pkg::result_type  result
);
   import chd_pkg::*;

   stop_mode_type         mode_ff;
   phase_type             phase_ff;
   phase_type             phase_in;
   logic [LenWidth-1:0]   length_ff;
   logic [LenWidth-1:0]   length_in;
   logic [LenWidth-1:0]   length_dec;
   hex_type               hex;
   logic                  len_zero;
   logic                  at_final_ext;
   phase_type             size_line_end;
   phase_type             blank_end;

   assign hex          = hex_decode(item.in_byte);
   assign len_zero     = (length_ff == '0);
   assign at_final_ext = len_zero && (mode_ff == MODE_AT_FINAL_EXT);
   assign length_dec   = len_zero ? length_ff : LenWidth'(length_ff - 1'b1);

   always_comb begin
      if (!len_zero) begin
         size_line_end = PH_DATA;
      end else if (mode_ff == MODE_AT_TRAILER) begin
         size_line_end = PH_DONE;
      end else begin
         size_line_end = PH_TRL;
      end
      blank_end = (mode_ff == MODE_ADOPT) ? PH_WAIT_EOF : PH_DONE;
   end

   // Next phase and counter
   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      if (item.end_of_input) begin
         phase_in = (phase_ff == PH_DONE || phase_ff == PH_WAIT_EOF) ? PH_DONE : PH_ERR;
      end else begin
         unique case (phase_ff)
            PH_LEN: begin
               if (hex.ok) begin
                  // a digit with any of the top nibble set would overflow
                  if (length_ff[LenWidth-1 -: 4] != 4'd0) begin
                     phase_in = PH_ERR;
                  end else begin
                     length_in = {length_ff[LenWidth-5:0], hex.val};
                  end
               end else if (at_final_ext) begin
                  phase_in = PH_DONE;
               end else if (item.in_byte == CharLf) begin
                  phase_in = size_line_end;
               end else begin
                  phase_in = PH_EXT;
               end
            end
            PH_EXT: begin
               if (item.in_byte == CharLf) begin
                  phase_in = size_line_end;
               end
            end
            PH_DATA: begin
               length_in = length_dec;
               if (length_dec == '0) begin
                  phase_in = PH_TERM;
               end
            end
            PH_TERM: begin
               if (item.in_byte == CharLf) begin
                  phase_in = PH_LEN;
               end else if (item.in_byte == CharCr) begin
                  phase_in = PH_TERM_CR;
               end else begin
                  phase_in = PH_ERR;
               end
            end
            PH_TERM_CR: begin
               phase_in = (item.in_byte == CharLf) ? PH_LEN : PH_ERR;
            end
            PH_TRL: begin
               if (item.in_byte == CharLf) begin
                  phase_in = blank_end;
               end else if (item.in_byte == CharCr) begin
                  phase_in = PH_TRL_CR;
               end else begin
                  phase_in = PH_TRL_SKIP;
               end
            end
            PH_TRL_SKIP: begin
               if (item.in_byte == CharLf) begin
                  phase_in = PH_TRL;
               end
            end
            PH_TRL_CR: begin
               phase_in = (item.in_byte == CharLf) ? blank_end : PH_TRL_SKIP;
            end
            PH_WAIT_EOF: phase_in = PH_ERR;
            PH_DONE:     phase_in = PH_DONE;
            default:     phase_in = PH_ERR;
         endcase
      end
   end

   // Result for the transaction in hand
   always_comb begin
      result.out_byte = 8'd0;
      result.out_kind = KIND_NONE;
      if (!item.end_of_input) begin
         unique case (phase_ff)
            PH_LEN: begin
               if (!hex.ok && at_final_ext) begin
                  result.out_byte = item.in_byte;
                  result.out_kind = KIND_LEFTOVER;
               end
            end
            PH_DATA: begin
               result.out_byte = item.in_byte;
               result.out_kind = KIND_PAYLOAD;
            end
            PH_DONE: begin
               result.out_byte = item.in_byte;
               result.out_kind = KIND_LEFTOVER;
            end
            default: result.out_kind = KIND_NONE;
         endcase
      end
      if (phase_in == PH_ERR) begin
         result.out_byte = 8'd0;
         result.out_kind = KIND_NONE;
         result.status   = STATUS_ERROR;
      end else if (phase_in == PH_DONE) begin
         result.status = STATUS_FINISHED;
      end else begin
         result.status = STATUS_DECODING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_AFTER_TRAILER;
         phase_ff  <= PH_LEN;
         length_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= stop_mode_type'(csr_wr_data);
         end
         if (fire) begin
            phase_ff  <= phase_in;
            length_ff <= length_in;
         end
      end
   end

endmodule

[design/chd_out_stage.sv]
module chd_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  chd_pkg::result_type  result,
   output logic                 out_ready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [7:0] out_byte
   output logic [3:0]           rsp_tuser    // [1:0] out_kind, [3:2] status
);
   import chd_pkg::*;

   logic       valid_ff;
   result_type result_ff;

   assign out_ready = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_ready) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load && out_ready) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = result_ff.out_byte;
   assign rsp_tuser  = {result_ff.status, result_ff.out_kind};

endmodule

[design/http_chunked_decoder_unit.sv]
// The request is registered in the input stage and the result in the output stage; rsp_ back-pressure stalls both.
// Throughput: one byte per cycle while rsp_tready is not held low; the phase and length counter update per byte.
// Every input transaction yields exactly one result transaction.
// Reset (synchronous, active high) empties both stages, sets the phase to length
// digits, clears the length counter and sets stop_mode to 1.
module http_chunked_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,   // stop_mode
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] in_byte
   input  logic        req_tlast,     // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,     // [7:0] out_byte
   output logic [3:0]  rsp_tuser      // [1:0] out_kind, [3:2] status
);
   import chd_pkg::*;

   logic       out_ready;
   logic       item_valid;
   logic       fire;
   item_type   item;
   result_type result;

   assign fire = item_valid && out_ready;

   chd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .out_ready  (out_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   chd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .item        (item),
      .result      (result)
   );

   chd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (item_valid),
      .result     (result),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[design/chd_checker.sv]
module chd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [3:0] rsp_tuser
);
   import chd_pkg::*;

   // Hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_err_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3:2] == STATUS_ERROR |->
         rsp_tuser[1:0] == KIND_NONE && rsp_tdata == 8'd0)
      else $error("error result carries data");

   a_kind_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tuser[1:0] == KIND_NONE) ||
         (rsp_tuser[1:0] == KIND_PAYLOAD && rsp_tuser[3:2] == STATUS_DECODING) ||
         (rsp_tuser[1:0] == KIND_LEFTOVER && rsp_tuser[3:2] == STATUS_FINISHED))
      else $error("kind does not match status");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind http_chunked_decoder_unit chd_checker u_chd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[dv/tb_http_chunked_decoder_unit.sv]
module tb_http_chunked_decoder_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import chd_pkg::*;

   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned LongHoldAt = 300;
   localparam int unsigned LongHoldCycles = 100;

   typedef struct packed {
      logic [7:0] b;
      logic       eoi;
      logic       typed;
      result_type want;
   } row_type;

   typedef enum int {
      END_AT_TRAILER,
      END_AFTER_TRAILER,
      END_ADOPT,
      END_FINAL_EXT,
      END_OVERFLOW,
      END_BAD_TERM,
      END_EARLY_EOI,
      END_ADOPT_BYTE
   } ending_type;

   localparam result_type NoOutput = '{8'h00, KIND_NONE, STATUS_DECODING};
   localparam int DirectedRows = 22;

   // "02" chunk with extreme payload bytes, zero-padded size with an extension,
   // LF-only terminator, then a payload CR closed by CR LF
   localparam row_type Directed[DirectedRows] = '{
      '{"0",    1'b0, 1'b1, NoOutput},
      '{"2",    1'b0, 1'b1, NoOutput},
      '{CharLf, 1'b0, 1'b1, NoOutput},
      '{8'h00,  1'b0, 1'b1, '{8'h00, KIND_PAYLOAD, STATUS_DECODING}},
      '{8'hff,  1'b0, 1'b1, '{8'hff, KIND_PAYLOAD, STATUS_DECODING}},
      '{CharCr, 1'b0, 1'b1, NoOutput},
      '{CharLf, 1'b0, 1'b1, NoOutput},
      '{"0",    1'b0, 1'b1, NoOutput},
      '{"0",    1'b0, 1'b1, NoOutput},
      '{"1",    1'b0, 1'b1, NoOutput},
      '{";",    1'b0, 1'b0, NoOutput},
      '{8'h80,  1'b0, 1'b0, NoOutput},
      '{"9",    1'b0, 1'b0, NoOutput},
      '{CharCr, 1'b0, 1'b0, NoOutput},
      '{CharLf, 1'b0, 1'b0, NoOutput},
      '{CharLf, 1'b0, 1'b1, '{CharLf, KIND_PAYLOAD, STATUS_DECODING}},
      '{CharLf, 1'b0, 1'b1, NoOutput},
      '{"1",    1'b0, 1'b1, NoOutput},
      '{CharLf, 1'b0, 1'b1, NoOutput},
      '{CharCr, 1'b0, 1'b1, '{CharCr, KIND_PAYLOAD, STATUS_DECODING}},
      '{CharCr, 1'b0, 1'b1, NoOutput},
      '{CharLf, 1'b0, 1'b1, NoOutput}
   };

   localparam stop_mode_type BodyModes[4] = '{
      MODE_AT_TRAILER, MODE_AT_FINAL_EXT, MODE_ADOPT, MODE_AFTER_TRAILER
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [1:0] csr_wr_data = 2'd0;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [3:0] rsp_tuser;

   // decoder state as the stimulus side sees it
   phase_type             ph;
   logic [LenWidth-1:0]   rem_len;
   stop_mode_type         mode_now;

   result_type    decoded_q[$];
   int unsigned   items_sent = 0;
   int unsigned   results_seen = 0;
   int unsigned   errors = 0;
   int unsigned   cycles = 0;
   bit            steady = 1'b0;

   http_chunked_decoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("tb_http_chunked_decoder_unit: errors");
         $finish;
      end
   end

   // bit 4 flags a hex digit, bits 3:0 carry its value
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      if (b >= "0" && b <= "9") begin
         return {1'b1, b[3:0]};
      end
      if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
         return {1'b1, b[3:0] + 4'd9};
      end
      return 5'd0;
   endfunction

   function automatic void end_size_line();
      if (rem_len != '0) begin
         ph = PH_DATA;
      end else if (mode_now == MODE_AT_TRAILER) begin
         ph = PH_DONE;
      end else begin
         ph = PH_TRL;
      end
   endfunction

   function automatic void end_trailer();
      ph = (mode_now == MODE_ADOPT) ? PH_WAIT_EOF : PH_DONE;
   endfunction

   function automatic result_type decode_step(input logic [7:0] b, input logic eoi);
      result_type r;
      logic [4:0] nib;
      r = NoOutput;
      nib = hex_digit(b);
      if (eoi) begin
         ph = (ph == PH_DONE || ph == PH_WAIT_EOF) ? PH_DONE : PH_ERR;
      end else begin
         case (ph)
            PH_LEN: begin
               if (nib[4]) begin
                  // a set top nibble cannot take another digit
                  if (rem_len[LenWidth-1 -: 4] != 4'd0) begin
                     ph = PH_ERR;
                  end else begin
                     rem_len = {rem_len[LenWidth-5:0], nib[3:0]};
                  end
               end else if (rem_len == '0 && mode_now == MODE_AT_FINAL_EXT) begin
                  ph = PH_DONE;
                  r.out_byte = b;
                  r.out_kind = KIND_LEFTOVER;
               end else if (b == CharLf) begin
                  end_size_line();
               end else begin
                  ph = PH_EXT;
               end
            end
            PH_EXT: begin
               if (b == CharLf) begin
                  end_size_line();
               end
            end
            PH_DATA: begin
               r.out_byte = b;
               r.out_kind = KIND_PAYLOAD;
               if (rem_len != '0) begin
                  rem_len = rem_len - 1'b1;
               end
               if (rem_len == '0) begin
                  ph = PH_TERM;
               end
            end
            PH_TERM: begin
               if (b == CharLf) begin
                  ph = PH_LEN;
               end else if (b == CharCr) begin
                  ph = PH_TERM_CR;
               end else begin
                  ph = PH_ERR;
               end
            end
            PH_TERM_CR: begin
               ph = (b == CharLf) ? PH_LEN : PH_ERR;
            end
            PH_TRL: begin
               if (b == CharLf) begin
                  end_trailer();
               end else if (b == CharCr) begin
                  ph = PH_TRL_CR;
               end else begin
                  ph = PH_TRL_SKIP;
               end
            end
            PH_TRL_SKIP: begin
               if (b == CharLf) begin
                  ph = PH_TRL;
               end
            end
            PH_TRL_CR: begin
               if (b == CharLf) begin
                  end_trailer();
               end else begin
                  ph = PH_TRL_SKIP;
               end
            end
            PH_DONE: begin
               r.out_byte = b;
               r.out_kind = KIND_LEFTOVER;
            end
            default: begin
               ph = PH_ERR;
            end
         endcase
      end
      if (ph == PH_ERR) begin
         r = '{8'h00, KIND_NONE, STATUS_ERROR};
      end else if (ph == PH_DONE) begin
         r.status = STATUS_FINISHED;
      end else begin
         r.status = STATUS_DECODING;
      end
      return r;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eoi, input logic typed,
                            input result_type want);
      int gap;
      result_type r;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = decode_step(b, eoi);
      decoded_q.push_back(typed ? want : r);
      items_sent++;
   endtask

   task automatic put(input logic [7:0] b);
      send_byte(b, 1'b0, 1'b0, NoOutput);
   endtask

   // drain everything, then write the mode while the block is idle
   task automatic set_stop_mode(input stop_mode_type m);
      req_tvalid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      mode_now = m;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] c;
      if (n < 4'd10) begin
         c = 8'h30 + 8'(n);
      end else begin
         c = (($urandom_range(0, 1) == 1) ? 8'h61 : 8'h41) + 8'(n - 4'd10);
      end
      return c;
   endfunction

   function automatic logic [7:0] rand_line_byte();
      logic [7:0] b;
      b = 8'($urandom());
      while (b == CharLf) b = 8'($urandom());
      return b;
   endfunction

   function automatic logic [7:0] rand_non_hex();
      logic [7:0] b;
      b = rand_line_byte();
      while (hex_digit(b) != 5'd0) b = rand_line_byte();
      return b;
   endfunction

   task automatic send_size(input logic [LenWidth-1:0] value);
      int top;
      int k;
      top = 0;
      repeat ($urandom_range(0, 2)) put("0");
      for (k = 0; k < LenWidth / 4; k++) begin
         if (value[4*k +: 4] != 4'd0) top = k;
      end
      for (k = top; k >= 0; k--) begin
         put(hex_char(value[4*k +: 4]));
      end
   endtask

   task automatic send_size_line(input logic [LenWidth-1:0] value);
      send_size(value);
      if ($urandom_range(0, 2) == 0) begin
         put(rand_non_hex());
         repeat ($urandom_range(0, 4)) put(rand_line_byte());
      end
      put(CharLf);
   endtask

   task automatic send_chunk();
      logic [LenWidth-1:0] size;
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
      send_size_line(size);
      repeat (size) put(8'($urandom()));
      if ($urandom_range(0, 1) == 1) put(CharCr);
      put(CharLf);
   endtask

   task automatic send_trailer();
      repeat ($urandom_range(0, 3)) begin
         // a leading CR with more text is a header line, not the blank one
         put(($urandom_range(0, 3) == 0) ? CharCr : rand_line_byte());
         repeat ($urandom_range(1, 5)) put(rand_line_byte());
         if ($urandom_range(0, 1) == 1) put(CharCr);
         put(CharLf);
      end
      if ($urandom_range(0, 1) == 1) put(CharCr);
      put(CharLf);
   endtask

   initial begin : stimulus
      int i;
      int p;
      int unsigned target;
      ending_type ending;
      ph = PH_LEN;
      rem_len = '0;
      mode_now = MODE_AFTER_TRAILER;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < DirectedRows; i++) begin
         send_byte(Directed[i].b, Directed[i].eoi, Directed[i].typed, Directed[i].want);
      end

      // long well-formed body, one stop mode per stretch
      for (p = 0; p < 6; p++) begin
         set_stop_mode((p < 4) ? BodyModes[p] : stop_mode_type'($urandom_range(0, 3)));
         target = items_sent + 110;
         while (items_sent < target) begin
            steady = ($urandom_range(0, 5) == 0);
            send_chunk();
         end
      end
      steady = 1'b0;

      ending = ending_type'($urandom_range(0, 7));
      case (ending)
         END_AT_TRAILER: begin
            set_stop_mode(MODE_AT_TRAILER);
            send_size_line('0);
         end
         END_AFTER_TRAILER: begin
            set_stop_mode(MODE_AFTER_TRAILER);
            send_size_line('0);
            send_trailer();
         end
         END_ADOPT: begin
            set_stop_mode(MODE_ADOPT);
            send_size_line('0);
            send_trailer();
            send_byte(8'($urandom()), 1'b1, 1'b0, NoOutput);
         end
         END_FINAL_EXT: begin
            set_stop_mode(MODE_AT_FINAL_EXT);
            send_size('0);
            put(($urandom_range(0, 1) == 1) ? CharLf : rand_non_hex());
         end
         END_OVERFLOW: begin
            put(hex_char(4'($urandom_range(1, 15))));
            repeat (9) put(hex_char(4'($urandom())));
         end
         END_BAD_TERM: begin
            send_size_line($urandom_range(1, 4));
            while (ph == PH_DATA) put(8'($urandom()));
            if ($urandom_range(0, 1) == 1) begin
               put(CharCr);
               put(rand_line_byte());
            end else begin
               put(($urandom_range(0, 1) == 1) ? 8'h00 : rand_non_hex());
            end
         end
         END_EARLY_EOI: begin
            repeat ($urandom_range(0, 2)) put(hex_char(4'($urandom())));
            send_byte(8'($urandom()), 1'b1, 1'b0, NoOutput);
         end
         default: begin
            set_stop_mode(MODE_ADOPT);
            send_size_line('0);
            send_trailer();
            put(8'($urandom()));
         end
      endcase

      // leftover bytes after the stop, or sticky error
      repeat (150) begin
         send_byte(8'($urandom()), ($urandom_range(0, 7) == 0), 1'b0, NoOutput);
      end
      req_tvalid <= 1'b0;

      while (decoded_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("tb_http_chunked_decoder_unit: clean");
      end else begin
         $display("tb_http_chunked_decoder_unit: errors");
      end
      $finish;
   end

   initial begin : drain
      int stall;
      result_type want;
      bit held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         if (decoded_q.size() == 0) begin
            if (errors < 10) begin
               $display("unexpected result transaction: byte %02h kind %0d status %0d",
                        rsp_tdata, rsp_tuser[1:0], rsp_tuser[3:2]);
            end
            errors++;
         end else begin
            want = decoded_q.pop_front();
            if (rsp_tdata !== want.out_byte || rsp_tuser[1:0] !== want.out_kind ||
                rsp_tuser[3:2] !== want.status) begin
               if (errors < 10) begin
                  $display("result %0d: want byte %02h kind %0d status %0d, got %02h %0d %0d",
                           results_seen, want.out_byte, want.out_kind, want.status,
                           rsp_tdata, rsp_tuser[1:0], rsp_tuser[3:2]);
               end
               errors++;
            end
         end
         results_seen++;
         // hold off once so the block backs up and stalls its input
         if (!held && results_seen == LongHoldAt) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LongHoldCycles) @(posedge clock);
         end
      end
   end

endmodule
